FILE: hdl/vrd_pkg.sv
// ----------------------------------------------------------------------------
// vrd_pkg: shared types and constants for the vector rotation pipeline
// Item layouts, fixed-point widths and the angle tables used by the front and the cells.
// ----------------------------------------------------------------------------
package vrd_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_WIDTH     = 16;
    localparam int DATA_WIDTH      = 32;
    localparam int GUARD_BITS      = 12;
    localparam int ROUND_WIDTH     = DATA_WIDTH - GUARD_BITS;
    localparam int EXT_WIDTH       = COORD_WIDTH + 1;
    localparam int ABS_WIDTH       = ANGLE_WIDTH + 1;
    localparam int ANGLE_TABLE_LEN = 24;

    localparam int ANGLE_DIV    = 45;
    localparam int RECIP_WIDTH  = 17;
    localparam int RECIP_SHIFT  = 22;
    localparam int QUOT_WIDTH   = 10;
    localparam int REM_WIDTH    = 6;
    localparam int FRAC_WIDTH   = 23;
    localparam int FRAC_DEPTH   = ANGLE_DIV;
    localparam int PROD_WIDTH   = ABS_WIDTH + RECIP_WIDTH;
    localparam int GAIN_SHIFT   = 18;
    localparam int SCALE_WIDTH  = 48;

    localparam logic [RECIP_WIDTH-1:0]  RECIP_DIV    = 17'd93207;
    localparam logic signed [DATA_WIDTH-1:0] QUARTER_TURN = 32'sh4000_0000;
    localparam logic signed [DATA_WIDTH-1:0] GAIN_Q30     = 32'sd652032874;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [ANGLE_WIDTH-1:0] turn_angle;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic                          clipped;
    } rot_out_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
    } cell_t;

    typedef logic signed [DATA_WIDTH-1:0] atan_table_t [ANGLE_TABLE_LEN];
    typedef logic [FRAC_WIDTH-1:0]        frac_table_t [FRAC_DEPTH];

    // atan(2^-i) in units of 2^-32 turn
    localparam atan_table_t ATAN_TABLE = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    function automatic frac_table_t build_frac_table();
        frac_table_t t;
        for (int r = 0; r < FRAC_DEPTH; r++)
        begin
            t[r] = FRAC_WIDTH'((longint'(r) << FRAC_WIDTH) / ANGLE_DIV);
        end
        return t;
    endfunction

    // floor(r * 2^23 / 45) for each remainder r
    localparam frac_table_t FRAC_TABLE = build_frac_table();

endpackage

FILE: hdl/vector_rotate_degrees.sv
// ----------------------------------------------------------------------------
// vector_rotate_degrees: planar point rotation by a CORDIC cell chain
//
//   channel | direction | payload    | handshake
//   in      | sink      | point_in_t | in_valid / in_ready
//   out     | source    | rot_out_t  | out_valid / out_ready
//
// One item per cycle sustained while the output is not stalled; each item
// passes three front stages, one cell per rotation stage and the output register.
// Reset clears only the valid flags; no item is in flight afterwards.
// The front stages and cells freeze while the skid stage holds an item; in_ready
// is a register output and drops only then.
// ----------------------------------------------------------------------------
module vector_rotate_degrees #(
    parameter int ROTATION_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vrd_pkg::point_in_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output vrd_pkg::rot_out_t  out_item
);
    import vrd_pkg::*;

    logic  advance;
    logic  valid_chain [ROTATION_STAGES+1];
    cell_t data_chain  [ROTATION_STAGES+1];

    assign in_ready = advance;

    vrd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .valid_out (valid_chain[0]),
        .data_out  (data_chain[0])
    );

    for (genvar i = 0; i < ROTATION_STAGES; i++)
    begin : g_cell
        vrd_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (valid_chain[i]),
            .data_in   (data_chain[i]),
            .valid_out (valid_chain[i+1]),
            .data_out  (data_chain[i+1])
        );
    end

    vrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_chain[ROTATION_STAGES]),
        .data_in   (data_chain[ROTATION_STAGES]),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: hdl/vrd_front.sv
// ----------------------------------------------------------------------------
// vrd_front: angle conversion, quadrant fold and gain prescale
// Three stages turning an input item into the first cell's x, y and z.
// ----------------------------------------------------------------------------
module vrd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  vrd_pkg::point_in_t in_item,
    output logic               valid_out,
    output vrd_pkg::cell_t     data_out
);
    import vrd_pkg::*;

    logic signed [ABS_WIDTH-1:0]   angle_ext;
    logic [ABS_WIDTH-1:0]          abs_next;
    logic [PROD_WIDTH-1:0]         quot_prod;
    logic [QUOT_WIDTH-1:0]         quot_next;

    logic                          s1_valid_reg;
    logic signed [COORD_WIDTH-1:0] s1_x_reg;
    logic signed [COORD_WIDTH-1:0] s1_y_reg;
    logic [ABS_WIDTH-1:0]          s1_abs_reg;
    logic                          s1_neg_reg;
    logic [QUOT_WIDTH-1:0]         s1_quot_reg;

    logic [ABS_WIDTH-1:0]          quot_times;
    logic [REM_WIDTH-1:0]          rem;
    logic [DATA_WIDTH-1:0]         z_abs;
    logic signed [DATA_WIDTH-1:0]  z_turn;
    logic signed [EXT_WIDTH-1:0]   x_ext;
    logic signed [EXT_WIDTH-1:0]   y_ext;
    logic signed [EXT_WIDTH-1:0]   x_next;
    logic signed [EXT_WIDTH-1:0]   y_next;
    logic signed [DATA_WIDTH-1:0]  z_next;

    logic                          s2_valid_reg;
    logic signed [EXT_WIDTH-1:0]   s2_x_reg;
    logic signed [EXT_WIDTH-1:0]   s2_y_reg;
    logic signed [DATA_WIDTH-1:0]  s2_z_reg;

    logic signed [SCALE_WIDTH-1:0] scale_x;
    logic signed [SCALE_WIDTH-1:0] scale_y;
    cell_t                         data_next;

    logic                          valid_reg;
    cell_t                         data_reg;

    // quotient of |angle| / 45 by reciprocal multiply
    always_comb
    begin
        angle_ext = EXT_WIDTH'(in_item.turn_angle);
        abs_next  = angle_ext[ABS_WIDTH-1] ? ABS_WIDTH'(-angle_ext) : ABS_WIDTH'(angle_ext);
        quot_prod = PROD_WIDTH'(abs_next) * PROD_WIDTH'(RECIP_DIV);
        quot_next = QUOT_WIDTH'(quot_prod >> RECIP_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg    <= in_item.point_x;
            s1_y_reg    <= in_item.point_y;
            s1_abs_reg  <= abs_next;
            s1_neg_reg  <= in_item.turn_angle[ANGLE_WIDTH-1];
            s1_quot_reg <= quot_next;
        end
    end

    // binary angle and quadrant fold
    always_comb
    begin
        quot_times = ABS_WIDTH'(s1_quot_reg) * ABS_WIDTH'(ANGLE_DIV);
        rem        = REM_WIDTH'(s1_abs_reg - quot_times);
        z_abs      = (DATA_WIDTH'(s1_quot_reg) << FRAC_WIDTH) + DATA_WIDTH'(FRAC_TABLE[rem]);
        z_turn     = s1_neg_reg ? -signed'(z_abs) : signed'(z_abs);
        x_ext      = EXT_WIDTH'(s1_x_reg);
        y_ext      = EXT_WIDTH'(s1_y_reg);
        x_next     = x_ext;
        y_next     = y_ext;
        z_next     = z_turn;
        if (z_turn > QUARTER_TURN)
        begin
            x_next = -y_ext;
            y_next = x_ext;
            z_next = z_turn - QUARTER_TURN;
        end
        else if (z_turn < -QUARTER_TURN)
        begin
            x_next = y_ext;
            y_next = -x_ext;
            z_next = z_turn + QUARTER_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_x_reg <= x_next;
            s2_y_reg <= y_next;
            s2_z_reg <= z_next;
        end
    end

    // gain prescale, leaving guard fraction bits
    always_comb
    begin
        scale_x = SCALE_WIDTH'(s2_x_reg) * SCALE_WIDTH'(GAIN_Q30)
                  + (SCALE_WIDTH'(1) <<< (GAIN_SHIFT - 1));
        scale_y = SCALE_WIDTH'(s2_y_reg) * SCALE_WIDTH'(GAIN_Q30)
                  + (SCALE_WIDTH'(1) <<< (GAIN_SHIFT - 1));
        data_next.x = DATA_WIDTH'(scale_x >>> GAIN_SHIFT);
        data_next.y = DATA_WIDTH'(scale_y >>> GAIN_SHIFT);
        data_next.z = s2_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

FILE: hdl/vrd_cell.sv
// ----------------------------------------------------------------------------
// vrd_cell: one CORDIC rotation cell
// Shift-add micro-rotation steered by the sign of the residual angle.
// ----------------------------------------------------------------------------
module vrd_cell #(
    parameter int STAGE = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           valid_in,
    input  vrd_pkg::cell_t data_in,
    output logic           valid_out,
    output vrd_pkg::cell_t data_out
);
    import vrd_pkg::*;

    localparam logic signed [DATA_WIDTH-1:0] STEP_ANGLE = ATAN_TABLE[STAGE];

    logic signed [DATA_WIDTH-1:0] x_in;
    logic signed [DATA_WIDTH-1:0] y_in;
    logic signed [DATA_WIDTH-1:0] dx;
    logic signed [DATA_WIDTH-1:0] dy;
    cell_t                        data_next;
    logic                         valid_reg;
    cell_t                        data_reg;

    always_comb
    begin
        x_in = data_in.x;
        y_in = data_in.y;
        dx   = y_in >>> STAGE;
        dy   = x_in >>> STAGE;
        if (!data_in.z[DATA_WIDTH-1])
        begin
            data_next.x = x_in - dx;
            data_next.y = y_in + dy;
            data_next.z = data_in.z - STEP_ANGLE;
        end
        else
        begin
            data_next.x = x_in + dx;
            data_next.y = y_in - dy;
            data_next.z = data_in.z + STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

FILE: hdl/vrd_back.sv
// ----------------------------------------------------------------------------
// vrd_back: rounding, saturation and output register with skid stage
// Drops guard bits, clips to the coordinate range and holds items for the sink.
// ----------------------------------------------------------------------------
module vrd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  vrd_pkg::cell_t    data_in,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output vrd_pkg::rot_out_t out_item
);
    import vrd_pkg::*;

    localparam logic signed [ROUND_WIDTH-1:0] SAT_HI =
        (ROUND_WIDTH'(1) <<< (COORD_WIDTH - 1)) - ROUND_WIDTH'(1);
    localparam logic signed [ROUND_WIDTH-1:0] SAT_LO = -SAT_HI - ROUND_WIDTH'(1);
    localparam logic signed [DATA_WIDTH-1:0]  ROUND_HALF =
        DATA_WIDTH'(1) <<< (GUARD_BITS - 1);

    logic signed [ROUND_WIDTH-1:0] round_x;
    logic signed [ROUND_WIDTH-1:0] round_y;
    logic                          hit_x;
    logic                          hit_y;
    rot_out_t                      item_next;

    logic                          out_valid_reg;
    rot_out_t                      out_item_reg;
    logic                          skid_valid_reg;
    rot_out_t                      skid_item_reg;

    always_comb
    begin
        round_x = ROUND_WIDTH'((data_in.x + ROUND_HALF) >>> GUARD_BITS);
        round_y = ROUND_WIDTH'((data_in.y + ROUND_HALF) >>> GUARD_BITS);
        hit_x   = (round_x > SAT_HI) || (round_x < SAT_LO);
        hit_y   = (round_y > SAT_HI) || (round_y < SAT_LO);

        if (round_x > SAT_HI)
            item_next.rotated_x = COORD_WIDTH'(SAT_HI);
        else if (round_x < SAT_LO)
            item_next.rotated_x = COORD_WIDTH'(SAT_LO);
        else
            item_next.rotated_x = COORD_WIDTH'(round_x);

        if (round_y > SAT_HI)
            item_next.rotated_y = COORD_WIDTH'(SAT_HI);
        else if (round_y < SAT_LO)
            item_next.rotated_y = COORD_WIDTH'(SAT_LO);
        else
            item_next.rotated_y = COORD_WIDTH'(round_y);

        item_next.clipped = hit_x || hit_y;
    end

    assign advance = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || (valid_in && advance);
            skid_valid_reg <= 1'b0;
        end
        else if (valid_in && advance)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            out_item_reg <= skid_valid_reg ? skid_item_reg : item_next;
        end
        else if (valid_in && advance)
        begin
            skid_item_reg <= item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: hdl/vrd_checker.sv
// ----------------------------------------------------------------------------
// vrd_checker: port-level checks for the rotation block
// Output hold rules, back-pressure relation and the saturation flag.
// ----------------------------------------------------------------------------
module vrd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input vrd_pkg::point_in_t in_item,
    input logic               out_valid,
    input logic               out_ready,
    input vrd_pkg::rot_out_t  out_item
);
    import vrd_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before the item was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
    else $error("out_item changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !$past(out_ready))
    else $error("input held off without a stalled item at the output");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.clipped |->
            out_item.rotated_x == 16'sh7fff || out_item.rotated_x == 16'sh8000 ||
            out_item.rotated_y == 16'sh7fff || out_item.rotated_y == 16'sh8000)
    else $error("clipped set with no coordinate at a limit");

endmodule

bind vector_rotate_degrees vrd_checker u_vrd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
